// File: design/chord_template_matcher_assert.svh
// Assertion macros shared by the chord template matcher modules
`ifndef CHORD_TEMPLATE_MATCHER_ASSERT_SVH
`define CHORD_TEMPLATE_MATCHER_ASSERT_SVH

// same-cycle implication
`define CTM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctm assertion failed");

// next-cycle implication
`define CTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctm assertion failed");

`endif

// File: design/ctm_pkg.sv
// Types, constants and table functions of the chord template matcher
package ctm_pkg;

    localparam int NUM_TYPES = 10;
    localparam int NUM_SUGG  = 4;

    typedef logic [3:0] pc_t;
    typedef logic [3:0] ctype_t;
    typedef logic [3:0][3:0] iv_row_t;

    localparam ctype_t TYPE_MAJ  = 4'd0;
    localparam ctype_t TYPE_DOM7 = 4'd4;
    localparam ctype_t TYPE_LAST = 4'd9;
    localparam pc_t    ROOT_LAST = 4'd11;
    localparam pc_t    STEP_DOM  = 4'd4;
    localparam logic [6:0] NOTE_BASE = 7'd60;
    localparam logic [7:0] CONF_MIN  = 8'd60;
    localparam logic [7:0] CONF_MAX  = 8'd200;
    localparam logic [7:0] CONF_DFLT = 8'd160;

    typedef struct packed {
        logic       capture;
        logic       scan_init;
        logic       scan_step;
        logic       clear_set;
        logic       build;
        logic       rank;
        logic       load_out;
        logic       load_default;
        logic [1:0] out_idx;
    } ctm_cmd_t;

    typedef struct packed {
        logic set_empty;
        logic scan_done;
        logic out_last;
    } ctm_status_t;

    function automatic pc_t pc_add(input pc_t a, input pc_t b);
        logic [4:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= 5'd12)
            sum = sum - 5'd12;
        return sum[3:0];
    endfunction

    function automatic logic [2:0] tmpl_size(input ctype_t t);
        logic [2:0] s;
        unique case (t)
            4'd2, 4'd3, 4'd4, 4'd9: s = 3'd4;
            default:                s = 3'd3;
        endcase
        return s;
    endfunction

    // element [3] is the first interval
    function automatic iv_row_t tmpl_iv(input ctype_t t);
        iv_row_t row;
        unique case (t)
            4'd0:    row = 16'h0470;
            4'd1:    row = 16'h0370;
            4'd2:    row = 16'h047B;
            4'd3:    row = 16'h037A;
            4'd4:    row = 16'h047A;
            4'd5:    row = 16'h0360;
            4'd6:    row = 16'h0480;
            4'd7:    row = 16'h0270;
            4'd8:    row = 16'h0570;
            4'd9:    row = 16'h0472;
            default: row = 16'h0470;
        endcase
        return row;
    endfunction

    // commonality in tenths
    function automatic logic [3:0] tmpl_common(input ctype_t t);
        logic [3:0] c;
        unique case (t)
            4'd0:    c = 4'd10;
            4'd1:    c = 4'd9;
            4'd2:    c = 4'd8;
            4'd3:    c = 4'd8;
            4'd4:    c = 4'd7;
            4'd5:    c = 4'd4;
            4'd6:    c = 4'd3;
            4'd7:    c = 4'd5;
            4'd8:    c = 4'd5;
            4'd9:    c = 4'd6;
            default: c = 4'd0;
        endcase
        return c;
    endfunction

    // commonality * 12 / size
    function automatic logic [7:0] tmpl_weight(input ctype_t t);
        logic [7:0] w;
        unique case (t)
            4'd0:    w = 8'd40;
            4'd1:    w = 8'd36;
            4'd2:    w = 8'd24;
            4'd3:    w = 8'd24;
            4'd4:    w = 8'd21;
            4'd5:    w = 8'd16;
            4'd6:    w = 8'd12;
            4'd7:    w = 8'd20;
            4'd8:    w = 8'd20;
            4'd9:    w = 8'd18;
            default: w = 8'd0;
        endcase
        return w;
    endfunction

    // element [3] is the first step; rows above the table saturate
    function automatic iv_row_t prog_row(input logic [2:0] row_sel);
        iv_row_t row;
        unique case (row_sel)
            3'd0:    row = 16'h0450;
            3'd1:    row = 16'h0534;
            3'd2:    row = 16'h0340;
            3'd3:    row = 16'h0530;
            default: row = 16'h0250;
        endcase
        return row;
    endfunction

    function automatic logic [4:0] conf_mult(input logic [1:0] i);
        logic [4:0] m;
        unique case (i)
            2'd0:    m = 5'd20;
            2'd1:    m = 5'd17;
            2'd2:    m = 5'd14;
            default: m = 5'd11;
        endcase
        return m;
    endfunction

    function automatic logic [6:0] voice_note(input pc_t pc, input pc_t cur);
        logic [6:0] n;
        pc_t d;
        n = NOTE_BASE + {3'd0, pc};
        d = (pc > cur) ? pc - cur : cur - pc;
        if (d > 4'd6)
            n = (pc < cur) ? n + 7'd12 : n - 7'd12;
        return n;
    endfunction

endpackage

// File: design/chord_template_matcher.sv
// Chord template matcher: note collection, 120-step template scan, four suggestions
// Non-last beats: taken one per cycle while idle (note_stall low), no result.
// Last beat: the scan runs one root/type pair per cycle, then build, rank and
// load follow in their own states; then the first suggestion appears, and
// then one per cycle while the sink does not stall. Empty set: one default suggestion.
// Reset (rst_n low, async) clears the pitch-class set and all control state.
module chord_template_matcher (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       note_valid,
    output logic       note_stall,
    input  logic [6:0] note,
    input  logic       note_present,
    input  logic [2:0] progression_choice,
    input  logic       last,
    output logic       sugg_valid,
    input  logic       sugg_stall,
    output logic [3:0] sugg_root,
    output logic [3:0] sugg_type,
    output logic [2:0] note_count,
    output logic [6:0] voice_a,
    output logic [6:0] voice_b,
    output logic [6:0] voice_c,
    output logic [6:0] voice_d,
    output logic [7:0] confidence,
    output logic       last_of_run
);

    ctm_pkg::ctm_cmd_t    cmd;
    ctm_pkg::ctm_status_t status;

    ctm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .note_valid (note_valid),
        .last       (last),
        .note_stall (note_stall),
        .sugg_valid (sugg_valid),
        .sugg_stall (sugg_stall),
        .status     (status),
        .cmd        (cmd)
    );

    ctm_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .note               (note),
        .note_present       (note_present),
        .progression_choice (progression_choice),
        .sugg_root          (sugg_root),
        .sugg_type          (sugg_type),
        .note_count         (note_count),
        .voice_a            (voice_a),
        .voice_b            (voice_b),
        .voice_c            (voice_c),
        .voice_d            (voice_d),
        .confidence         (confidence),
        .last_of_run        (last_of_run)
    );

endmodule

// File: design/ctm_ctrl.sv
// Controller state machine of the chord template matcher
`include "chord_template_matcher_assert.svh"

module ctm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 note_valid,
    input  logic                 last,
    output logic                 note_stall,
    output logic                 sugg_valid,
    input  logic                 sugg_stall,
    input  ctm_pkg::ctm_status_t status,
    output ctm_pkg::ctm_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_BUILD,
        S_RANK,
        S_LOAD,
        S_EMIT
    } state_t;

    state_t     state_reg;
    logic [1:0] beat_reg;
    logic       sugg_valid_reg;
    logic       accept;

    assign note_stall = (state_reg != S_IDLE);
    assign sugg_valid = sugg_valid_reg;
    assign accept     = note_valid && (state_reg == S_IDLE);

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture   = accept;
                cmd.scan_init = accept && last;
            end
            S_SCAN:
            begin
                if (status.set_empty)
                    cmd.load_default = 1'b1;
                else
                begin
                    cmd.scan_step = 1'b1;
                    cmd.clear_set = status.scan_done;
                end
            end
            S_BUILD: cmd.build = 1'b1;
            S_RANK:  cmd.rank  = 1'b1;
            S_LOAD:
            begin
                cmd.load_out = 1'b1;
                cmd.out_idx  = 2'd0;
            end
            S_EMIT:
            begin
                if (!sugg_stall && !status.out_last)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_idx  = beat_reg + 2'd1;
                end
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            beat_reg       <= 2'd0;
            sugg_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && last)
                        state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (status.set_empty)
                    begin
                        state_reg      <= S_EMIT;
                        sugg_valid_reg <= 1'b1;
                    end
                    else if (status.scan_done)
                        state_reg <= S_BUILD;
                end
                S_BUILD: state_reg <= S_RANK;
                S_RANK:  state_reg <= S_LOAD;
                S_LOAD:
                begin
                    state_reg      <= S_EMIT;
                    beat_reg       <= 2'd0;
                    sugg_valid_reg <= 1'b1;
                end
                S_EMIT:
                begin
                    if (!sugg_stall)
                    begin
                        if (status.out_last)
                        begin
                            state_reg      <= S_IDLE;
                            sugg_valid_reg <= 1'b0;
                        end
                        else
                            beat_reg <= beat_reg + 2'd1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `CTM_ASSERT_NOW(a_valid_in_emit, clk, rst_n, sugg_valid_reg, state_reg == S_EMIT)
    `CTM_ASSERT_NEXT(a_last_starts_scan, clk, rst_n, cmd.scan_init, state_reg == S_SCAN)

endmodule

// File: design/ctm_dp.sv
// Datapath of the chord template matcher: pitch set, template scan, suggestions
`include "chord_template_matcher_assert.svh"

module ctm_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctm_pkg::ctm_cmd_t    cmd,
    output ctm_pkg::ctm_status_t status,
    input  logic [6:0]           note,
    input  logic                 note_present,
    input  logic [2:0]           progression_choice,
    output logic [3:0]           sugg_root,
    output logic [3:0]           sugg_type,
    output logic [2:0]           note_count,
    output logic [6:0]           voice_a,
    output logic [6:0]           voice_b,
    output logic [6:0]           voice_c,
    output logic [6:0]           voice_d,
    output logic [7:0]           confidence,
    output logic                 last_of_run
);

    logic [11:0]     pcs_reg;
    ctm_pkg::pc_t    scan_root_reg;
    ctm_pkg::ctype_t scan_type_reg;
    logic [7:0]      best_reg;
    ctm_pkg::pc_t    cur_root_reg;
    ctm_pkg::ctype_t cur_type_reg;
    logic [2:0]      choice_reg;

    ctm_pkg::pc_t    s_root_reg [ctm_pkg::NUM_SUGG];
    ctm_pkg::ctype_t s_type_reg [ctm_pkg::NUM_SUGG];
    logic [7:0]      s_conf_reg [ctm_pkg::NUM_SUGG];
    logic [1:0]      s_rank_reg [ctm_pkg::NUM_SUGG];

    logic [3:0]      sugg_root_reg;
    logic [3:0]      sugg_type_reg;
    logic [2:0]      note_count_reg;
    logic [6:0]      voice_a_reg;
    logic [6:0]      voice_b_reg;
    logic [6:0]      voice_c_reg;
    logic [6:0]      voice_d_reg;
    logic [7:0]      confidence_reg;
    logic            last_of_run_reg;

    logic [3:0]      note_pc;
    logic [7:0]      score;
    logic            scan_done;

    ctm_pkg::pc_t    b_root [ctm_pkg::NUM_SUGG];
    ctm_pkg::ctype_t b_type [ctm_pkg::NUM_SUGG];
    logic [7:0]      b_conf [ctm_pkg::NUM_SUGG];
    logic [1:0]      r_rank [ctm_pkg::NUM_SUGG];
    logic [ctm_pkg::NUM_SUGG-1:0] sel_hit;

    ctm_pkg::pc_t    e_root;
    ctm_pkg::ctype_t e_type;
    logic [7:0]      e_conf;
    ctm_pkg::iv_row_t e_iv;

    // note mod 12: 7-bit value, up to ten subtractions of 12 folded into four compares (96, 48, 24, 12)
    always_comb
    begin
        logic [6:0] v;
        v = note;
        if (v >= 7'd96) v = v - 7'd96;
        if (v >= 7'd48) v = v - 7'd48;
        if (v >= 7'd24) v = v - 7'd24;
        if (v >= 7'd12) v = v - 7'd12;
        note_pc = v[3:0];
    end

    // one root/type pair per cycle
    always_comb
    begin
        ctm_pkg::iv_row_t iv;
        logic [2:0]       m;
        logic [2:0]       size;
        logic [10:0]      prod;
        iv   = ctm_pkg::tmpl_iv(scan_type_reg);
        size = ctm_pkg::tmpl_size(scan_type_reg);
        m    = 3'd0;
        for (int k = 0; k < 4; k++)
        begin
            if ((3'(k) < size) && pcs_reg[ctm_pkg::pc_add(scan_root_reg, iv[3-k])])
                m = m + 3'd1;
        end
        prod  = {8'd0, m} * {3'd0, ctm_pkg::tmpl_weight(scan_type_reg)};
        score = prod[7:0];
    end

    assign scan_done = (scan_root_reg == ctm_pkg::ROOT_LAST)
                    && (scan_type_reg == ctm_pkg::TYPE_LAST);

    always_comb
    begin
        ctm_pkg::iv_row_t row;
        logic [8:0]       c;
        row = ctm_pkg::prog_row(choice_reg);
        for (int i = 0; i < ctm_pkg::NUM_SUGG; i++)
        begin
            b_root[i] = ctm_pkg::pc_add(cur_root_reg, row[3-i]);
            b_type[i] = ((i != 0) && (row[3-i] == ctm_pkg::STEP_DOM))
                      ? ctm_pkg::TYPE_DOM7 : cur_type_reg;
            c = {5'd0, ctm_pkg::tmpl_common(b_type[i])}
              * {4'd0, ctm_pkg::conf_mult(2'(i))};
            if (c < {1'b0, ctm_pkg::CONF_MIN})
                c = {1'b0, ctm_pkg::CONF_MIN};
            if (c > {1'b0, ctm_pkg::CONF_MAX})
                c = {1'b0, ctm_pkg::CONF_MAX};
            b_conf[i] = c[7:0];
        end
    end

    // stable descending position of each suggestion
    always_comb
    begin
        for (int i = 0; i < ctm_pkg::NUM_SUGG; i++)
        begin
            r_rank[i] = 2'd0;
            for (int j = 0; j < ctm_pkg::NUM_SUGG; j++)
            begin
                if ((j != i) && ((s_conf_reg[j] > s_conf_reg[i])
                    || ((j < i) && (s_conf_reg[j] == s_conf_reg[i]))))
                    r_rank[i] = r_rank[i] + 2'd1;
            end
        end
    end

    always_comb
    begin
        e_root = '0;
        e_type = '0;
        e_conf = '0;
        for (int i = 0; i < ctm_pkg::NUM_SUGG; i++)
        begin
            sel_hit[i] = (s_rank_reg[i] == cmd.out_idx);
            if (sel_hit[i])
            begin
                e_root = s_root_reg[i];
                e_type = s_type_reg[i];
                e_conf = s_conf_reg[i];
            end
        end
        e_iv = ctm_pkg::tmpl_iv(e_type);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcs_reg       <= '0;
            scan_root_reg <= '0;
            scan_type_reg <= '0;
        end
        else
        begin
            if (cmd.capture && note_present)
                pcs_reg[note_pc] <= 1'b1;
            else if (cmd.clear_set)
                pcs_reg <= '0;
            if (cmd.scan_init)
            begin
                scan_root_reg <= '0;
                scan_type_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                if (scan_type_reg == ctm_pkg::TYPE_LAST)
                begin
                    scan_type_reg <= '0;
                    scan_root_reg <= scan_root_reg + 4'd1;
                end
                else
                    scan_type_reg <= scan_type_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            best_reg     <= '0;
            cur_root_reg <= '0;
            cur_type_reg <= ctm_pkg::TYPE_MAJ;
            choice_reg   <= progression_choice;
        end
        else if (cmd.scan_step && (score > best_reg))
        begin
            best_reg     <= score;
            cur_root_reg <= scan_root_reg;
            cur_type_reg <= scan_type_reg;
        end
        for (int i = 0; i < ctm_pkg::NUM_SUGG; i++)
        begin
            if (cmd.build)
            begin
                s_root_reg[i] <= b_root[i];
                s_type_reg[i] <= b_type[i];
                s_conf_reg[i] <= b_conf[i];
            end
            if (cmd.rank)
                s_rank_reg[i] <= r_rank[i];
        end
        if (cmd.load_default)
        begin
            sugg_root_reg   <= '0;
            sugg_type_reg   <= ctm_pkg::TYPE_MAJ;
            note_count_reg  <= 3'd3;
            voice_a_reg     <= 7'd60;
            voice_b_reg     <= 7'd64;
            voice_c_reg     <= 7'd67;
            voice_d_reg     <= 7'd0;
            confidence_reg  <= ctm_pkg::CONF_DFLT;
            last_of_run_reg <= 1'b1;
        end
        else if (cmd.load_out)
        begin
            sugg_root_reg   <= e_root;
            sugg_type_reg   <= e_type;
            note_count_reg  <= ctm_pkg::tmpl_size(e_type);
            voice_a_reg     <= ctm_pkg::voice_note(ctm_pkg::pc_add(e_root, e_iv[3]),
                                                   cur_root_reg);
            voice_b_reg     <= ctm_pkg::voice_note(ctm_pkg::pc_add(e_root, e_iv[2]),
                                                   cur_root_reg);
            voice_c_reg     <= ctm_pkg::voice_note(ctm_pkg::pc_add(e_root, e_iv[1]),
                                                   cur_root_reg);
            voice_d_reg     <= (ctm_pkg::tmpl_size(e_type) == 3'd4)
                             ? ctm_pkg::voice_note(ctm_pkg::pc_add(e_root, e_iv[0]),
                                                   cur_root_reg)
                             : 7'd0;
            confidence_reg  <= e_conf;
            last_of_run_reg <= (cmd.out_idx == 2'd3);
        end
    end

    assign status.set_empty = (pcs_reg == 12'd0);
    assign status.scan_done = scan_done;
    assign status.out_last  = last_of_run_reg;

    assign sugg_root   = sugg_root_reg;
    assign sugg_type   = sugg_type_reg;
    assign note_count  = note_count_reg;
    assign voice_a     = voice_a_reg;
    assign voice_b     = voice_b_reg;
    assign voice_c     = voice_c_reg;
    assign voice_d     = voice_d_reg;
    assign confidence  = confidence_reg;
    assign last_of_run = last_of_run_reg;

    `CTM_ASSERT_NOW(a_rank_perm, clk, rst_n, cmd.load_out, $onehot(sel_hit))
    `CTM_ASSERT_NEXT(a_set_cleared, clk, rst_n, cmd.clear_set, pcs_reg == 12'd0)

endmodule

// File: sim/chord_match_sb_pkg.sv
// Chord tables, expected-suggestion record and scoreboard for the chord template matcher bench
package chord_match_sb_pkg;

    localparam int unsigned CHORD_SIZE [10] = '{3, 3, 4, 4, 4, 3, 3, 3, 3, 4};
    localparam int unsigned CHORD_IV [10][4] = '{
        '{0, 4, 7, 0}, '{0, 3, 7, 0}, '{0, 4, 7, 11}, '{0, 3, 7, 10}, '{0, 4, 7, 10},
        '{0, 3, 6, 0}, '{0, 4, 8, 0}, '{0, 2, 7, 0}, '{0, 5, 7, 0}, '{0, 4, 7, 2}};
    // commonality in tenths
    localparam int unsigned CHORD_COMMON [10] = '{10, 9, 8, 8, 7, 4, 3, 5, 5, 6};
    localparam int unsigned PROG_STEPS [5][4] = '{
        '{0, 4, 5, 0}, '{0, 5, 3, 4}, '{0, 3, 4, 0}, '{0, 5, 3, 0}, '{0, 2, 5, 0}};
    localparam int unsigned LAST_ROW = 4;

    typedef struct {
        ctm_pkg::pc_t   root;
        ctm_pkg::ctype_t kind;
        logic [2:0]     count;
        logic [6:0]     va;
        logic [6:0]     vb;
        logic [6:0]     vc;
        logic [6:0]     vd;
        logic [7:0]     conf;
        logic           fin;
    } suggestion_t;

    class chord_scoreboard;

        logic [11:0]  held_pcs;
        suggestion_t  expected_q[$];
        int           errors;

        function new();
            held_pcs = '0;
            errors = 0;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void add_expected(suggestion_t s);
            expected_q.insert(expected_q.size(), s);
        endfunction

        function logic [6:0] place_voice(int unsigned pc, int unsigned center);
            int unsigned n;
            int unsigned c;
            int unsigned d;
            n = ctm_pkg::NOTE_BASE + pc;
            c = ctm_pkg::NOTE_BASE + center;
            d = (n > c) ? n - c : c - n;
            if (d > 6)
                n = (n < c) ? n + 12 : n - 12;
            return n[6:0];
        endfunction

        function void note_beat(logic [6:0] note, logic present, logic [2:0] choice,
                                logic is_last);
            int unsigned best;
            int unsigned root;
            int unsigned kind;
            int unsigned hits;
            int unsigned score;
            int unsigned row;
            int unsigned stp;
            int unsigned ty;
            int unsigned c;
            int unsigned s_root [4];
            int unsigned s_kind [4];
            int unsigned s_conf [4];
            int unsigned base;
            int ord [4];
            int v;
            int j;
            suggestion_t s;
            if (present)
                held_pcs[note % 12] = 1'b1;
            if (!is_last)
                return;
            if (held_pcs == '0)
            begin
                s.root = '0;
                s.kind = ctm_pkg::TYPE_MAJ;
                s.count = 3'd3;
                s.va = ctm_pkg::NOTE_BASE;
                s.vb = ctm_pkg::NOTE_BASE + 7'd4;
                s.vc = ctm_pkg::NOTE_BASE + 7'd7;
                s.vd = '0;
                s.conf = ctm_pkg::CONF_DFLT;
                s.fin = 1'b1;
                add_expected(s);
                return;
            end
            best = 0;
            root = 0;
            kind = 0;
            for (int r = 0; r < 12; r++)
            begin
                for (int t = 0; t < 10; t++)
                begin
                    hits = 0;
                    for (int k = 0; k < CHORD_SIZE[t]; k++)
                        if (held_pcs[(r + CHORD_IV[t][k]) % 12])
                            hits++;
                    score = hits * CHORD_COMMON[t] * ((CHORD_SIZE[t] == 3) ? 4 : 3);
                    if (hits > 0 && score > best)
                    begin
                        best = score;
                        root = r;
                        kind = t;
                    end
                end
            end
            held_pcs = '0;
            row = (choice > LAST_ROW) ? LAST_ROW : choice;
            for (int i = 0; i < 4; i++)
            begin
                stp = PROG_STEPS[row][i];
                ty = (i > 0 && stp == ctm_pkg::STEP_DOM) ? ctm_pkg::TYPE_DOM7 : kind;
                c = CHORD_COMMON[ty] * (20 - 3 * i);
                if (c < ctm_pkg::CONF_MIN)
                    c = 32'(ctm_pkg::CONF_MIN);
                if (c > ctm_pkg::CONF_MAX)
                    c = 32'(ctm_pkg::CONF_MAX);
                s_root[i] = (root + stp) % 12;
                s_kind[i] = ty;
                s_conf[i] = c;
                ord[i] = i;
            end
            // stable, descending confidence
            for (int n = 1; n < 4; n++)
            begin
                v = ord[n];
                j = n - 1;
                while (j >= 0 && s_conf[ord[j]] < s_conf[v])
                begin
                    ord[j + 1] = ord[j];
                    j--;
                end
                ord[j + 1] = v;
            end
            for (int n = 0; n < 4; n++)
            begin
                v = ord[n];
                ty = s_kind[v];
                base = s_root[v];
                s.root = base[3:0];
                s.kind = ty[3:0];
                s.count = 3'(CHORD_SIZE[ty]);
                s.va = place_voice((base + CHORD_IV[ty][0]) % 12, root);
                s.vb = place_voice((base + CHORD_IV[ty][1]) % 12, root);
                s.vc = place_voice((base + CHORD_IV[ty][2]) % 12, root);
                s.vd = (CHORD_SIZE[ty] == 4) ?
                       place_voice((base + CHORD_IV[ty][3]) % 12, root) : 7'd0;
                s.conf = 8'(s_conf[v]);
                s.fin = (n == 3);
                add_expected(s);
            end
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(suggestion_t got);
            suggestion_t want;
            if (expected_q.size() == 0)
            begin
                $error("suggestion beat with nothing expected: root %0d type %0d",
                       got.root, got.kind);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            check_field("sugg_root", 8'(want.root), 8'(got.root));
            check_field("sugg_type", 8'(want.kind), 8'(got.kind));
            check_field("note_count", 8'(want.count), 8'(got.count));
            check_field("voice_a", 8'(want.va), 8'(got.va));
            check_field("voice_b", 8'(want.vb), 8'(got.vb));
            check_field("voice_c", 8'(want.vc), 8'(got.vc));
            check_field("voice_d", 8'(want.vd), 8'(got.vd));
            check_field("confidence", want.conf, got.conf);
            check_field("last_of_run", 8'(want.fin), 8'(got.fin));
        endfunction

    endclass

endpackage

// File: sim/tb.sv
// Testbench top for the chord template matcher: stimulus, sink and end-of-run check
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BEATS  = 430;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 300;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       note_valid = 1'b0;
    logic       note_stall;
    logic [6:0] note = '0;
    logic       note_present = 1'b0;
    logic [2:0] progression_choice = '0;
    logic       last = 1'b0;
    logic       sugg_valid;
    logic       sugg_stall = 1'b0;
    logic [3:0] sugg_root;
    logic [3:0] sugg_type;
    logic [2:0] note_count;
    logic [6:0] voice_a;
    logic [6:0] voice_b;
    logic [6:0] voice_c;
    logic [6:0] voice_d;
    logic [7:0] confidence;
    logic       last_of_run;

    chord_match_sb_pkg::chord_scoreboard sb = new();
    logic calm = 1'b0;
    int   hold_reqs = 0;
    int   hold_done = 0;
    int   hold_left = 0;
    int   beats = 0;
    int   cycles = 0;

    chord_template_matcher DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .note_valid         (note_valid),
        .note_stall         (note_stall),
        .note               (note),
        .note_present       (note_present),
        .progression_choice (progression_choice),
        .last               (last),
        .sugg_valid         (sugg_valid),
        .sugg_stall         (sugg_stall),
        .sugg_root          (sugg_root),
        .sugg_type          (sugg_type),
        .note_count         (note_count),
        .voice_a            (voice_a),
        .voice_b            (voice_b),
        .voice_c            (voice_c),
        .voice_d            (voice_d),
        .confidence         (confidence),
        .last_of_run        (last_of_run)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // suggestion sink
    always @(posedge clk)
    begin : sink
        chord_match_sb_pkg::suggestion_t got;
        if (rst_n && sugg_valid && !sugg_stall)
        begin
            got.root = sugg_root;
            got.kind = sugg_type;
            got.count = note_count;
            got.va = voice_a;
            got.vb = voice_b;
            got.vc = voice_c;
            got.vd = voice_d;
            got.conf = confidence;
            got.fin = last_of_run;
            sb.check_result(got);
        end
        if (hold_reqs != hold_done)
        begin
            hold_done = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            sugg_stall <= 1'b1;
        end
        else
            sugg_stall <= !calm && ($urandom_range(99) < 26);
    end

    task automatic send_beat(input logic [6:0] n, input logic p, input logic [2:0] ch,
                             input logic l);
        while (!calm && $urandom_range(99) < 26)
        begin
            note_valid <= 1'b0;
            @(posedge clk);
        end
        note_valid <= 1'b1;
        note <= n;
        note_present <= p;
        progression_choice <= ch;
        last <= l;
        @(posedge clk);
        while (note_stall)
            @(posedge clk);
        sb.note_beat(n, p, ch, l);
        beats++;
    endtask

    task automatic wait_for_results();
        note_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // template-shaped note set, random octaves and order, some tones dropped, occasional stray notes
    task automatic random_chord();
        int unsigned r;
        int unsigned t;
        int unsigned pc;
        int notes[$];
        logic tail_absent;
        r = $urandom_range(0, 11);
        t = $urandom_range(0, 9);
        for (int k = 0; k < chord_match_sb_pkg::CHORD_SIZE[t]; k++)
        begin
            if ($urandom_range(99) < 85)
            begin
                pc = (r + chord_match_sb_pkg::CHORD_IV[t][k]) % 12;
                notes.insert($urandom_range(0, notes.size()),
                             int'(pc + 12 * $urandom_range(0, (127 - pc) / 12)));
            end
        end
        if ($urandom_range(99) < 20)
            notes.insert($urandom_range(0, notes.size()), int'($urandom_range(0, 127)));
        if ($urandom_range(99) < 3)
            notes.delete();
        tail_absent = (notes.size() == 0) || ($urandom_range(99) < 15);
        for (int i = 0; i < notes.size(); i++)
        begin
            if ($urandom_range(99) < 8)
                send_beat(7'($urandom_range(0, 127)), 1'b0, 3'($urandom_range(0, 7)),
                          1'b0);
            send_beat(7'(notes[i]), 1'b1, 3'($urandom_range(0, 7)),
                      !tail_absent && (i == notes.size() - 1));
        end
        if (tail_absent)
            send_beat(7'($urandom_range(0, 127)), 1'b0, 3'($urandom_range(0, 7)), 1'b1);
    endtask

    initial
    begin
        int random_start;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty set, choice above the table
        send_beat(7'd127, 1'b0, 3'd7, 1'b1);
        // lowest and highest notes
        send_beat(7'd0, 1'b1, 3'd0, 1'b0);
        send_beat(7'd127, 1'b1, 3'd5, 1'b1);
        send_beat(7'd60, 1'b1, 3'd0, 1'b0);
        send_beat(7'd63, 1'b1, 3'd0, 1'b0);
        send_beat(7'd67, 1'b1, 3'd1, 1'b1);
        send_beat(7'd62, 1'b1, 3'd0, 1'b0);
        send_beat(7'd66, 1'b1, 3'd0, 1'b0);
        send_beat(7'd69, 1'b1, 3'd0, 1'b0);
        send_beat(7'd72, 1'b1, 3'd2, 1'b1);
        // absent note closes the chord
        send_beat(7'd64, 1'b1, 3'd0, 1'b0);
        send_beat(7'd68, 1'b1, 3'd0, 1'b0);
        send_beat(7'd85, 1'b0, 3'd3, 1'b1);
        send_beat(7'd61, 1'b1, 3'd0, 1'b0);
        send_beat(7'd64, 1'b1, 3'd0, 1'b0);
        send_beat(7'd67, 1'b1, 3'd0, 1'b0);
        send_beat(7'd70, 1'b1, 3'd4, 1'b1);
        send_beat(7'd65, 1'b1, 3'd6, 1'b1);
        send_beat(7'd48, 1'b1, 3'd0, 1'b0);
        send_beat(7'd52, 1'b1, 3'd0, 1'b0);
        send_beat(7'd55, 1'b1, 3'd0, 1'b1);
        wait_for_results();

        // sink holds off while chords keep coming
        hold_reqs <= hold_reqs + 1;
        repeat (3) random_chord();
        wait_for_results();

        random_start = beats;
        while (beats - random_start < RANDOM_BEATS)
        begin
            calm <= (beats - random_start >= 150) && (beats - random_start < 240);
            if ($urandom_range(99) < 85)
                random_chord();
            else
                send_beat(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                          3'($urandom_range(0, 7)), $urandom_range(0, 9) == 0);
        end
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: chord_template_matcher.f
+incdir+design
design/ctm_pkg.sv
design/ctm_ctrl.sv
design/ctm_dp.sv
design/chord_template_matcher.sv
sim/chord_match_sb_pkg.sv
sim/tb.sv
